FILE: hdl/rcr_pkg.sv
`timescale 1ns / 1ps
// rcr_pkg: shared types, codes and defaults for the rectangle canvas rasterizer
// no dependencies; imported by rcr_canvas_mem, rcr_seq and the top level
package rcr_pkg;

  // default geometry
  localparam int CANVAS_SIDE_DEF = 512;
  localparam int FRAC_BITS_DEF   = 8;

  // fixed field widths
  localparam int COORD_W    = 20;
  localparam int CHAR_W     = 8;
  localparam int READ_W     = 9;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  // reset values of the registers
  localparam int              SIZE_RESET = 300;
  localparam logic [CHAR_W-1:0] BG_RESET = 8'h20;

  // shape type characters
  localparam logic [CHAR_W-1:0] CH_OUTLINE = 8'h72;
  localparam logic [CHAR_W-1:0] CH_FILLED  = 8'h52;

  // item opcodes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } rcr_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_RECT     = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } rcr_status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BG     = 2'd2
  } rcr_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_SETUP_A,
    S_SETUP_B,
    S_ROW,
    S_COL,
    S_RD_ADDR,
    S_RD_DATA,
    S_DONE
  } rcr_state_t;

  // finished item handed from the sequencer to the output register
  typedef struct packed {
    rcr_status_t       status;
    logic [CHAR_W-1:0] pixel;
  } rcr_result_t;

endpackage

FILE: hdl/rcr_canvas_mem.sv
`timescale 1ns / 1ps
// rcr_canvas_mem: single write port, single registered read port canvas memory
// depends on rcr_pkg for the character width
module rcr_canvas_mem
  import rcr_pkg::*;
#(
  parameter int ADDR_W = 18
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CHAR_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CHAR_W-1:0] rdata
);

  logic [CHAR_W-1:0] mem [1 << ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/rcr_span_test.sv
`timescale 1ns / 1ps
// rcr_span_test: shared compare unit, tests one coordinate against a closed span
// and against the inner band one unit in from each end; no dependencies
module rcr_span_test #(
  parameter int CMP_W = 22
) (
  input  logic signed [CMP_W-1:0] coord,
  input  logic signed [CMP_W-1:0] lo,
  input  logic signed [CMP_W-1:0] hi,
  input  logic signed [CMP_W-1:0] lo_band,
  input  logic signed [CMP_W-1:0] hi_band,
  output logic                    in_span,
  output logic                    near_end
);

  // inside the closed span, or within one unit of either end
  assign in_span  = (coord >= lo) && (coord <= hi);
  assign near_end = (coord < lo_band) || (coord > hi_band);

endmodule

FILE: hdl/rcr_seq.sv
`timescale 1ns / 1ps
// rcr_seq: item sequencer; walks the canvas with one shared span test unit
// depends on rcr_pkg, rcr_span_test and rcr_canvas_mem
module rcr_seq
  import rcr_pkg::*;
#(
  parameter  int CANVAS_SIDE = CANVAS_SIDE_DEF,
  parameter  int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int SIZE_W      = $clog2(CANVAS_SIDE + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [1:0]                in_opcode,
  input  logic [CHAR_W-1:0]         in_shape_type,
  input  logic signed [COORD_W-1:0] in_rect_left,
  input  logic signed [COORD_W-1:0] in_rect_top,
  input  logic signed [COORD_W-1:0] in_rect_width,
  input  logic signed [COORD_W-1:0] in_rect_height,
  input  logic [CHAR_W-1:0]         in_fill_char,
  input  logic [READ_W-1:0]         in_read_col,
  input  logic [READ_W-1:0]         in_read_row,
  input  logic [SIZE_W-1:0]         canvas_width,
  input  logic [SIZE_W-1:0]         canvas_height,
  input  logic [CHAR_W-1:0]         bg_char,
  input  logic                      out_free,
  output logic                      in_ready,
  output logic                      res_load,
  output rcr_result_t               result
);

  localparam int IDX_W  = (CANVAS_SIDE > 1) ? $clog2(CANVAS_SIDE) : 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int CNT_W  = SIZE_W + 1;
  localparam int RD_W   = (SIZE_W > READ_W) ? SIZE_W : READ_W;
  localparam int PIX_W  = IDX_W + FRAC_BITS + 1;
  localparam int CMP_W  = ((PIX_W > COORD_W + 1) ? PIX_W : COORD_W + 1) + 1;
  localparam logic signed [CMP_W-1:0] ONE_FIX = $signed(CMP_W'(1) << FRAC_BITS);

  rcr_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] sweep_addr_r;
  logic [CHAR_W-1:0] sweep_char_r;
  logic              sweep_reply_r;

  logic              outline_r;
  logic [CHAR_W-1:0] fill_r;
  logic signed [CMP_W-1:0] x_lo_r, x_hi_r, x_lob_r, x_hib_r;
  logic signed [CMP_W-1:0] y_lo_r, y_hi_r, y_lob_r, y_hib_r;
  logic [IDX_W-1:0]  row_r, col_r;
  logic              row_edge_r;
  rcr_status_t       status_r;
  logic [CHAR_W-1:0] pixel_r;

  logic              sweep_last, row_last, col_last;
  logic              draw_bad, rd_bad;
  logic [CNT_W-1:0]  row_cnt, col_cnt;

  logic signed [CMP_W-1:0] u_coord, u_lo, u_hi, u_lob, u_hib;
  logic              u_in_span, u_near;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  // item checks at accept
  assign draw_bad = ((in_shape_type != CH_OUTLINE) && (in_shape_type != CH_FILLED)) ||
                    in_rect_width[COORD_W-1] || (in_rect_width == '0) ||
                    in_rect_height[COORD_W-1] || (in_rect_height == '0);
  assign rd_bad   = (RD_W'(in_read_col) >= RD_W'(canvas_width)) ||
                    (RD_W'(in_read_row) >= RD_W'(canvas_height));

  // loop end detection
  assign sweep_last = (sweep_addr_r == '1);
  assign row_cnt    = CNT_W'(row_r) + CNT_W'(1);
  assign col_cnt    = CNT_W'(col_r) + CNT_W'(1);
  assign row_last   = (row_cnt == CNT_W'(canvas_height));
  assign col_last   = (col_cnt == CNT_W'(canvas_width));

  // shared span test: rows in S_ROW, columns otherwise
  always_comb begin
    if (state_r == S_ROW) begin
      u_coord = $signed(CMP_W'(row_r) << FRAC_BITS);
      u_lo    = y_lo_r;
      u_hi    = y_hi_r;
      u_lob   = y_lob_r;
      u_hib   = y_hib_r;
    end else begin
      u_coord = $signed(CMP_W'(col_r) << FRAC_BITS);
      u_lo    = x_lo_r;
      u_hi    = x_hi_r;
      u_lob   = x_lob_r;
      u_hib   = x_hib_r;
    end
  end

  rcr_span_test #(
    .CMP_W (CMP_W)
  ) u_span (
    .coord    (u_coord),
    .lo       (u_lo),
    .hi       (u_hi),
    .lo_band  (u_lob),
    .hi_band  (u_hib),
    .in_span  (u_in_span),
    .near_end (u_near)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_SWEEP: begin
        if (sweep_last) begin
          state_nxt = sweep_reply_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (rcr_op_t'(in_opcode))
            OP_CLEAR: state_nxt = S_SWEEP;
            OP_DRAW:  state_nxt = draw_bad ? S_DONE : S_SETUP_A;
            OP_READ:  state_nxt = rd_bad ? S_DONE : S_RD_ADDR;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_SETUP_A: state_nxt = S_SETUP_B;
      S_SETUP_B: state_nxt = S_ROW;
      S_ROW: begin
        if (u_in_span) begin
          state_nxt = S_COL;
        end else if (row_last) begin
          state_nxt = S_DONE;
        end
      end
      S_COL: begin
        if (col_last) begin
          state_nxt = row_last ? S_DONE : S_ROW;
        end
      end
      S_RD_ADDR: state_nxt = S_RD_DATA;
      S_RD_DATA: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_ready  = 1'b0;
    res_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = {row_r, col_r};
    mem_wdata = fill_r;
    mem_re    = 1'b0;
    mem_raddr = {row_r, col_r};
    case (state_r)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_r;
        mem_wdata = sweep_char_r;
      end
      S_IDLE:    in_ready = 1'b1;
      S_COL:     mem_we = u_in_span && (!outline_r || row_edge_r || u_near);
      S_RD_ADDR: mem_re = 1'b1;
      S_DONE:    res_load = out_free;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_SWEEP;
      sweep_addr_r  <= '0;
      sweep_char_r  <= BG_RESET;
      sweep_reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_SWEEP) begin
        sweep_addr_r <= sweep_addr_r + 1'b1;
      end
      if (in_fire && (rcr_op_t'(in_opcode) == OP_CLEAR)) begin
        sweep_addr_r  <= '0;
        sweep_char_r  <= bg_char;
        sweep_reply_r <= 1'b1;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_r  <= ST_OK;
          pixel_r   <= '0;
          outline_r <= (in_shape_type == CH_OUTLINE);
          fill_r    <= in_fill_char;
          x_lo_r    <= CMP_W'(in_rect_left);
          y_lo_r    <= CMP_W'(in_rect_top);
          x_hi_r    <= CMP_W'(in_rect_width);
          y_hi_r    <= CMP_W'(in_rect_height);
          row_r     <= IDX_W'(in_read_row);
          col_r     <= IDX_W'(in_read_col);
          if ((rcr_op_t'(in_opcode) == OP_DRAW) && draw_bad) begin
            status_r <= ST_BAD_RECT;
          end
          if ((rcr_op_t'(in_opcode) == OP_READ) && rd_bad) begin
            status_r <= ST_OUT_OF_RANGE;
          end
        end
      end
      // far edges and inner band starts
      S_SETUP_A: begin
        x_hi_r  <= x_lo_r + x_hi_r;
        y_hi_r  <= y_lo_r + y_hi_r;
        x_lob_r <= x_lo_r + ONE_FIX;
        y_lob_r <= y_lo_r + ONE_FIX;
      end
      // inner band ends, start at the top row
      S_SETUP_B: begin
        x_hib_r <= x_hi_r - ONE_FIX;
        y_hib_r <= y_hi_r - ONE_FIX;
        row_r   <= '0;
      end
      // row test, then either walk its columns or step on
      S_ROW: begin
        row_edge_r <= u_near;
        col_r      <= '0;
        if (!u_in_span) begin
          row_r <= row_r + 1'b1;
        end
      end
      S_COL: begin
        col_r <= col_r + 1'b1;
        if (col_last) begin
          row_r <= row_r + 1'b1;
        end
      end
      S_RD_DATA: pixel_r <= mem_rdata;
      default: begin
      end
    endcase
  end

  assign result.status = status_r;
  assign result.pixel  = pixel_r;

  rcr_canvas_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

FILE: hdl/rectangle_canvas_rasterizer_top.sv
`timescale 1ns / 1ps
// Rectangle canvas rasterizer. A character canvas of CANVAS_SIDE x CANVAS_SIDE cells sits in one
// memory with a single write port, and everything is driven through that port one cell per cycle.
// After reset the block runs a clearing pass over every cell of the memory, writing the space
// character, with in_ready low; configuration writes are taken during the pass. A clear item runs
// the same pass with the configured background character. A draw item sets up the far edges and
// inner bands, then walks the configured canvas height and width: each row is tested, and each
// column of a covered row is tested and painted. A bad rectangle, a read out of range and opcode 3
// go straight to the result; a read addresses the memory, then takes its data. One item is
// worked at a time; a finished result waits in the output register while the next item is
// taken. Depends on rcr_pkg and rcr_seq.
module rectangle_canvas_rasterizer_top
  import rcr_pkg::*;
#(
  parameter int CANVAS_SIDE = CANVAS_SIDE_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration port
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_opcode,
  input  logic [CHAR_W-1:0]         in_shape_type,
  input  logic signed [COORD_W-1:0] in_rect_left,
  input  logic signed [COORD_W-1:0] in_rect_top,
  input  logic signed [COORD_W-1:0] in_rect_width,
  input  logic signed [COORD_W-1:0] in_rect_height,
  input  logic [CHAR_W-1:0]         in_fill_char,
  input  logic [READ_W-1:0]         in_read_col,
  input  logic [READ_W-1:0]         in_read_row,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic [CHAR_W-1:0]         out_pixel_char
);

  localparam int SIZE_W = $clog2(CANVAS_SIDE + 1);
  localparam int V_W    = (SIZE_W > CFG_DATA_W) ? SIZE_W : CFG_DATA_W;
  localparam logic [SIZE_W-1:0] SIZE_RST =
    SIZE_W'((SIZE_RESET > CANVAS_SIDE) ? CANVAS_SIDE : SIZE_RESET);

  logic [SIZE_W-1:0] width_r, height_r, cfg_size;
  logic [CHAR_W-1:0] bg_r;
  logic [V_W-1:0]    cfg_v;

  logic              in_fire, out_free, res_load;
  rcr_result_t       result;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [CHAR_W-1:0] out_pixel_r;

  // clamp a written size to one through the canvas side
  assign cfg_v = V_W'(cfg_wdata);
  always_comb begin
    if (cfg_v == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (cfg_v > V_W'(CANVAS_SIDE)) begin
      cfg_size = SIZE_W'(CANVAS_SIDE);
    end else begin
      cfg_size = SIZE_W'(cfg_v);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RST;
      height_r <= SIZE_RST;
      bg_r     <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_size;
        REG_HEIGHT: height_r <= cfg_size;
        REG_BG:     bg_r     <= cfg_wdata[CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  rcr_seq #(
    .CANVAS_SIDE (CANVAS_SIDE),
    .FRAC_BITS   (FRAC_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_opcode      (in_opcode),
    .in_shape_type  (in_shape_type),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_fill_char   (in_fill_char),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .canvas_width   (width_r),
    .canvas_height  (height_r),
    .bg_char        (bg_r),
    .out_free       (out_free),
    .in_ready       (in_ready),
    .res_load       (res_load),
    .result         (result)
  );

  // output register, holds a result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r <= result.status;
      out_pixel_r  <= result.pixel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_pixel_char = out_pixel_r;

  // no item is taken in the first cycle after reset: the clearing pass runs
  a_sweep_after_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !in_ready)
    else $error("item port open during clearing pass");

  // the block is busy in the cycle after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("sequencer not busy after accept");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten");

  // every error result carries a zero pixel
  a_error_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_pixel_char == '0))
    else $error("error result with nonzero pixel");

endmodule
